FILE: rtl/vdi_pkg.sv
// ----------------------------------------------------------------------------
// Vertex dedup indexer package
// Shared types and float comparison helpers.
// ----------------------------------------------------------------------------
`default_nettype none
package vdi_pkg;

  localparam int unsigned NUM_COMP = 8;
  localparam int unsigned COMP_W = 32;
  localparam int unsigned VERT_W = NUM_COMP * COMP_W;
  localparam int unsigned IDX_OUT_W = 10;

  typedef logic [VERT_W-1:0] vert_t;

  typedef struct packed {
    logic  first;
    vert_t vert;
  } item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_DONE
  } state_t;

  function automatic logic is_nan(input logic [COMP_W-1:0] b);
    return b[COMP_W-2:0] > 31'h7F80_0000;
  endfunction

  function automatic logic comp_eq(input logic [COMP_W-1:0] a, input logic [COMP_W-1:0] b);
    logic r;
    r = 1'b0;
    if (is_nan(a) || is_nan(b)) begin
      r = 1'b0;
    end else if (a[COMP_W-2:0] == '0 && b[COMP_W-2:0] == '0) begin
      r = 1'b1;
    end else begin
      r = (a == b);
    end
    return r;
  endfunction

  function automatic logic vert_eq(input vert_t a, input vert_t b);
    logic r;
    r = 1'b1;
    for (int c = 0; c < NUM_COMP; c++) begin
      r = r & comp_eq(a[c*COMP_W +: COMP_W], b[c*COMP_W +: COMP_W]);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/vdi_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// Reads every cycle, writes when we is set; registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module vdi_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

FILE: rtl/vdi_queue.sv
// ----------------------------------------------------------------------------
// Vertex dedup indexer input queue
// Two-entry queue that parts the accepting front from the search engine.
// ----------------------------------------------------------------------------
`default_nettype none
module vdi_queue
  import vdi_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire item_t in_item,
  output logic       out_valid,
  input  wire logic  out_ready,
  output item_t      out_item
);

  item_t      slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_item  = slot[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_item;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

FILE: rtl/vdi_engine.sv
// ----------------------------------------------------------------------------
// Vertex dedup indexer search engine
// Scans the unique table one entry at a time; appends on a miss if not full.
// ----------------------------------------------------------------------------
`default_nettype none
module vdi_engine
  import vdi_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 item_valid,
  output logic                      item_ready,
  input  wire item_t                item,
  output logic                      res_valid,
  input  wire logic                 res_ready,
  output logic [IDX_OUT_W-1:0]      vertex_index,
  output logic                      is_new,
  output logic                      table_full
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = AW + 1;

  state_t         state;
  state_t         state_next;
  logic [CW-1:0]  count;
  logic [CW-1:0]  scan;
  item_t          cur;
  vert_t          rdata;
  logic           we;
  logic [AW-1:0]  addr;
  logic [CW-1:0]  limit;
  logic           hit;
  logic [CW-1:0]  res_idx;

  vdi_ram #(.WIDTH(VERT_W), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .addr  (addr),
    .wdata (cur.vert),
    .rdata (rdata)
  );

  assign limit = cur.first ? '0 : count;
  assign hit   = vert_eq(rdata, cur.vert);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (item_valid) state_next = ST_READ;
      ST_READ: if (scan >= limit) state_next = ST_DONE; else state_next = ST_CMP;
      ST_CMP:  if (hit) state_next = ST_DONE; else state_next = ST_READ;
      ST_DONE: if (res_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    item_ready = (state == ST_IDLE);
    res_valid  = (state == ST_DONE);
    we         = (state == ST_READ) && (scan >= limit) && (limit < CW'(TABLE_DEPTH));
    addr       = scan[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && item_valid) begin
      cur <= item;
    end
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      scan       <= '0;
      res_idx    <= '0;
      is_new     <= 1'b0;
      table_full <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: scan <= '0;
        ST_READ: begin
          if (scan >= limit) begin
            if (limit < CW'(TABLE_DEPTH)) begin
              res_idx    <= limit;
              is_new     <= 1'b1;
              table_full <= 1'b0;
              count      <= limit + 1'b1;
            end else begin
              res_idx    <= '0;
              is_new     <= 1'b0;
              table_full <= 1'b1;
              count      <= limit;
            end
          end
        end
        ST_CMP: begin
          if (hit) begin
            res_idx    <= scan;
            is_new     <= 1'b0;
            table_full <= 1'b0;
            count      <= limit;
          end else begin
            scan <= scan + 1'b1;
          end
        end
        ST_DONE: ;
        default: ;
      endcase
    end
  end

  assign vertex_index = IDX_OUT_W'(res_idx);

endmodule
`default_nettype wire

FILE: rtl/vertex_dedup_indexer.sv
// ----------------------------------------------------------------------------
// Vertex dedup indexer
// Maps each incoming vertex to an index in a table of unique vertices.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries one vertex per beat: eight IEEE
// single words and the first flag, which restarts the table for a new mesh.
// Output channel (out_valid/out_ready) returns one beat per vertex: the
// vertex_index, is_new when the vertex was appended, and table_full when a
// new vertex found no free entry (index 0 then).
// A two-entry queue takes input beats while the engine searches. The engine
// reads one table entry at a time from a single-port memory, in a READ and
// a CMP state per entry. On a miss it compares all N stored entries and then
// appends; on a hit at index K it stops after comparing entry K. The result
// is offered from registers and can be taken in the cycle it is offered.
// The result waits in the engine until taken; a stalled receiver holds the
// engine and then fills the queue. Reset empties the queue and the table.
// ----------------------------------------------------------------------------
`default_nettype none
module vertex_dedup_indexer
  import vdi_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 first,
  input  wire logic [31:0]          pos_x,
  input  wire logic [31:0]          pos_y,
  input  wire logic [31:0]          pos_z,
  input  wire logic [31:0]          tex_u,
  input  wire logic [31:0]          tex_v,
  input  wire logic [31:0]          norm_x,
  input  wire logic [31:0]          norm_y,
  input  wire logic [31:0]          norm_z,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [IDX_OUT_W-1:0]      vertex_index,
  output logic                      is_new,
  output logic                      table_full
);

  item_t in_item;
  item_t q_item;
  logic  q_valid;
  logic  q_ready;

  assign in_item.first = first;
  assign in_item.vert  = {norm_z, norm_y, norm_x, tex_v, tex_u, pos_z, pos_y, pos_x};

  vdi_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_item  (q_item)
  );

  vdi_engine #(.TABLE_DEPTH(TABLE_DEPTH)) u_engine (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (q_valid),
    .item_ready   (q_ready),
    .item         (q_item),
    .res_valid    (out_valid),
    .res_ready    (out_ready),
    .vertex_index (vertex_index),
    .is_new       (is_new),
    .table_full   (table_full)
  );

`ifndef SYNTHESIS
  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(is_new && table_full))
    else $error("is_new and table_full both set");
  a_full_idx0: assert property (@(posedge clk) disable iff (rst)
    (out_valid && table_full) |-> (vertex_index == '0))
    else $error("table_full with nonzero index");
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(vertex_index)))
    else $error("result changed while stalled");
`endif

endmodule
`default_nettype wire

FILE: dv/tb_vertex_dedup_indexer.sv
// ----------------------------------------------------------------------------
// Vertex dedup indexer testbench
// Drives vertices over the input channel and checks every result beat
// against a behavioural predictor of the unique table. It covers signed
// zeros, NaNs, a completely full table, small random meshes that reuse
// earlier vertices, and several idling and stalling phases.
// ----------------------------------------------------------------------------
`default_nettype none

typedef bit [31:0] vtx_t [8];

typedef struct {
  bit [9:0] vidx;
  bit       fresh;
  bit       full;
} idx_result_t;

class vertex_scoreboard;
  bit [31:0]   uniq [1024][8];
  int unsigned uniq_cnt;
  idx_result_t pending [$];
  int          errors;

  function bit nan_bits(bit [31:0] b);
    return b[30:0] > 31'h7F80_0000;
  endfunction

  function bit float_same(bit [31:0] a, bit [31:0] b);
    if (nan_bits(a) || nan_bits(b)) return 1'b0;
    if (a[30:0] == 31'd0 && b[30:0] == 31'd0) return 1'b1;
    return a == b;
  endfunction

  function void note_vertex(bit first, vtx_t v);
    idx_result_t r;
    bit hit;
    bit same;
    hit = 1'b0;
    r = '{vidx: 10'd0, fresh: 1'b0, full: 1'b0};
    if (first) uniq_cnt = 0;
    for (int i = 0; i < uniq_cnt && !hit; i++) begin
      same = 1'b1;
      for (int c = 0; c < 8; c++) same &= float_same(uniq[i][c], v[c]);
      if (same) begin
        hit = 1'b1;
        r.vidx = i[9:0];
      end
    end
    if (!hit) begin
      if (uniq_cnt < 1024) begin
        for (int c = 0; c < 8; c++) uniq[uniq_cnt][c] = v[c];
        r.vidx = uniq_cnt[9:0];
        r.fresh = 1'b1;
        uniq_cnt++;
      end else begin
        r.full = 1'b1;
      end
    end
    pending.insert(pending.size(), r);
  endfunction

  task report(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  task check_result(bit [9:0] vidx, bit fresh, bit full);
    idx_result_t e;
    if (pending.size() == 0) begin
      report("result beat with no vertex outstanding");
    end else begin
      e = pending.pop_front();
      if (vidx != e.vidx || fresh != e.fresh || full != e.full)
        report($sformatf("got idx %0d new %0d full %0d, wanted idx %0d new %0d full %0d",
                         vidx, fresh, full, e.vidx, e.fresh, e.full));
    end
  endtask
endclass

module tb_vertex_dedup_indexer;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk, rst;
  logic        in_valid, in_ready, first;
  logic [31:0] pos_x, pos_y, pos_z, tex_u, tex_v, norm_x, norm_y, norm_z;
  logic        out_valid, out_ready;
  logic [9:0]  vertex_index;
  logic        is_new, table_full;

  int          send_idle_pct;
  int          recv_stall_pct;
  vtx_t        seen [$];
  vertex_scoreboard sb;

  vertex_dedup_indexer dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .first(first),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .tex_u(tex_u), .tex_v(tex_v),
    .norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .vertex_index(vertex_index), .is_new(is_new), .table_full(table_full)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #500_000_000;
    $display("TB_ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready)
      sb.note_vertex(first, '{pos_x, pos_y, pos_z, tex_u, tex_v, norm_x, norm_y, norm_z});
    if (!rst && out_valid && out_ready)
      sb.check_result(vertex_index, is_new, table_full);
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task send_vertex(bit f, vtx_t v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    first  <= f;
    pos_x  <= v[0]; pos_y  <= v[1]; pos_z  <= v[2]; tex_u <= v[3];
    tex_v  <= v[4]; norm_x <= v[5]; norm_y <= v[6]; norm_z <= v[7];
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (seen.size() < 64) seen.insert(seen.size(), v);
    else seen[$urandom_range(63)] = v;
  endtask

  function bit [31:0] pick_word();
    bit [31:0] specials [10] = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000,
                                32'hFF80_0000, 32'h7FC0_0000, 32'h7F80_0001,
                                32'hFFFF_FFFF, 32'h3F80_0000, 32'h7F7F_FFFF,
                                32'h0000_0001};
    if ($urandom_range(3) == 0) return specials[$urandom_range(9)];
    if ($urandom_range(1) == 0) return $urandom_range(3);
    return $urandom;
  endfunction

  function vtx_t random_vertex();
    vtx_t v;
    for (int c = 0; c < 8; c++) v[c] = pick_word();
    return v;
  endfunction

  function vtx_t reused_vertex();
    vtx_t v;
    v = seen[$urandom_range(seen.size() - 1)];
    for (int c = 0; c < 8; c++) begin
      if (v[c][30:0] == 31'd0 && $urandom_range(1)) v[c][31] = ~v[c][31];
    end
    if ($urandom_range(9) == 0) v[$urandom_range(7)] ^= 32'd1 << $urandom_range(31);
    return v;
  endfunction

  task fill_table();
    vtx_t v;
    for (int i = 0; i < 1024; i++) begin
      for (int c = 0; c < 8; c++) v[c] = $urandom;
      v[0] = i;
      v[1] = 32'h4000_0000;
      send_vertex(i == 0, v);
    end
    for (int k = 0; k < 3; k++) begin
      for (int c = 0; c < 8; c++) v[c] = $urandom;
      v[1] = 32'h5000_0000;
      send_vertex(1'b0, v);
    end
    v = '{default: 32'h7FC0_0000};
    send_vertex(1'b0, v);
    send_vertex(1'b0, seen[$urandom_range(seen.size() - 1)]);
  endtask

  task random_meshes(int count);
    int left;
    int mesh_len;
    left = count;
    while (left > 0) begin
      mesh_len = $urandom_range(1, 24);
      for (int k = 0; k < mesh_len && left > 0; k++) begin
        if (k > 0 && $urandom_range(99) < 55) send_vertex(1'b0, reused_vertex());
        else send_vertex(k == 0 && $urandom_range(9) != 0, random_vertex());
        left--;
      end
    end
  endtask

  initial begin
    vtx_t v;
    int   wait_cycles;
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    first = 1'b0;
    {pos_x, pos_y, pos_z, tex_u, tex_v, norm_x, norm_y, norm_z} = '0;
    out_ready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    v = '{default: 32'h0000_0000};
    send_vertex(1'b1, v);
    v = '{default: 32'h8000_0000};
    send_vertex(1'b0, v);
    v = '{default: 32'hFFFF_FFFF};
    send_vertex(1'b0, v);
    send_vertex(1'b0, v);
    v = '{default: 32'h7F80_0000};
    send_vertex(1'b0, v);
    send_vertex(1'b0, v);
    v[3] = 32'h7F80_0001;
    send_vertex(1'b0, v);
    v = '{default: 32'hFF80_0000};
    send_vertex(1'b0, v);
    v = '{default: 32'h7FFF_FFFF};
    send_vertex(1'b0, v);
    v = '{32'h0, 32'h8000_0000, 32'h0, 32'h8000_0000,
          32'h3F80_0000, 32'h0, 32'h8000_0000, 32'h0};
    send_vertex(1'b0, v);
    v[0] = 32'h8000_0000; v[1] = 32'h0;
    send_vertex(1'b0, v);
    v = '{default: 32'h0000_0000};
    send_vertex(1'b0, v);
    send_vertex(1'b1, v);
    v = '{default: 32'h8000_0000};
    send_vertex(1'b1, v);

    fill_table();

    random_meshes(220);
    send_idle_pct = 81;
    random_meshes(220);
    send_idle_pct = 0;
    recv_stall_pct = 81;
    random_meshes(220);
    send_idle_pct = 36;
    recv_stall_pct = 36;
    random_meshes(220);

    in_valid <= 1'b0;
    wait_cycles = 0;
    while (sb.pending.size() != 0 && wait_cycles < 2_000_000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

`default_nettype wire
